[design/tst_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tst_pkg
// Shared types and constants of the software timer table: request codes,
// slot layout and the word types passed from the scan engine to the emitter.
// ----------------------------------------------------------------------------
package tst_pkg;

   localparam int NUM_TIMERS_DEFAULT = 16;
   localparam int MAX_RESULTS        = 16;
   localparam int FILL_W             = $clog2(MAX_RESULTS + 1);
   localparam int BUF_W              = $clog2(MAX_RESULTS);

   typedef enum logic [1:0] {
      REQ_TICK     = 2'd0,
      REQ_PERIODIC = 2'd1,
      REQ_ONESHOT  = 2'd2,
      REQ_CLEAR    = 2'd3
   } tst_req_kind_type;

   typedef enum logic {
      STATUS_OK   = 1'b0,
      STATUS_FULL = 1'b1
   } tst_status_type;

   typedef struct packed {
      logic [15:0] id;
      logic [31:0] interval;
      logic [47:0] deadline;
      logic        periodic;
   } tst_slot_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] id;
   } tst_push_type;

   typedef struct packed {
      logic           valid;
      logic [15:0]    new_id;
      tst_status_type status;
      logic [4:0]     count;
   } tst_done_type;

endpackage
`default_nettype wire

[design/tst_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tst_req_if
// Request channel: valid/ready handshake with the request word.
// ----------------------------------------------------------------------------
interface tst_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [47:0] now_ms;
   logic [31:0] interval_ms;
   logic [15:0] clear_id;

   modport source (output valid, output req_type, output now_ms, output interval_ms,
                   output clear_id, input ready);
   modport sink   (input valid, input req_type, input now_ms, input interval_ms,
                   input clear_id, output ready);
endinterface
`default_nettype wire

[design/tst_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tst_rsp_if
// Response channel: valid/ready handshake with the result word.
// ----------------------------------------------------------------------------
interface tst_rsp_if;
   logic        valid;
   logic        ready;
   logic        fired;
   logic [15:0] fired_id;
   logic [15:0] new_id;
   logic        status;
   logic [4:0]  active_count;
   logic        last;

   modport source (output valid, output fired, output fired_id, output new_id,
                   output status, output active_count, output last, input ready);
   modport sink   (input valid, input fired, input fired_id, input new_id,
                   input status, input active_count, input last, output ready);
endinterface
`default_nettype wire

[design/tst_scan.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tst_scan
// Slot memory and sequencer. One saturating adder is shared between creation
// and the per-slot tick scan, which also uses the one deadline compare; the
// tick/clear scan also compacts the table in place.
// ----------------------------------------------------------------------------
module tst_scan #(
   parameter int NUM_TIMERS = tst_pkg::NUM_TIMERS_DEFAULT
) (
   input  wire logic           clock,
   input  wire logic           reset,
   tst_req_if.sink             req_chan,
   input  wire logic           emit_free,
   output tst_pkg::tst_push_type push,
   output tst_pkg::tst_done_type done
);
   import tst_pkg::*;

   localparam int CW = $clog2(NUM_TIMERS + 1);
   localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_CREATE = 5'b00010,
      S_READ   = 5'b00100,
      S_EVAL   = 5'b01000,
      S_DONE   = 5'b10000
   } tst_state_type;

   tst_state_type    state_ff, state_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [15:0]      next_id_ff, next_id_in;
   tst_req_kind_type op_ff, op_in;
   logic [47:0]      now_ff, now_in;
   logic [31:0]      iv_ff, iv_in;
   logic [15:0]      cid_ff, cid_in;
   logic [IW-1:0]    rd_ff, rd_in;
   logic [CW-1:0]    wr_ff, wr_in;
   logic [FILL_W-1:0] nfire_ff, nfire_in;
   logic [15:0]      new_id_ff, new_id_in;
   tst_status_type   status_ff, status_in;

   tst_slot_type     slot_mem [NUM_TIMERS];
   tst_slot_type     rdata_ff;
   logic             mem_we;
   logic [IW-1:0]    mem_wa;
   tst_slot_type     mem_wd;

   logic [31:0]      add_iv;
   logic [48:0]      add_sum;
   logic [47:0]      add_sat;
   logic             due;
   logic             keep;
   logic             accept;

   assign req_chan.ready = (state_ff == S_IDLE) && emit_free;
   assign accept         = req_chan.valid && req_chan.ready;

   // shared saturating adder and deadline compare
   assign add_iv  = (state_ff == S_CREATE) ? iv_ff : rdata_ff.interval;
   assign add_sum = {1'b0, now_ff} + {17'd0, add_iv};
   assign add_sat = add_sum[48] ? {48{1'b1}} : add_sum[47:0];
   assign due     = (nfire_ff < FILL_W'(MAX_RESULTS)) && (now_ff >= rdata_ff.deadline);

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      next_id_in = next_id_ff;
      op_in      = op_ff;
      now_in     = now_ff;
      iv_in      = iv_ff;
      cid_in     = cid_ff;
      rd_in      = rd_ff;
      wr_in      = wr_ff;
      nfire_in   = nfire_ff;
      new_id_in  = new_id_ff;
      status_in  = status_ff;
      mem_we     = 1'b0;
      mem_wa     = wr_ff[IW-1:0];
      mem_wd     = rdata_ff;
      push       = '0;
      done       = '0;
      keep       = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = tst_req_kind_type'(req_chan.req_type);
               now_in    = req_chan.now_ms;
               iv_in     = req_chan.interval_ms;
               cid_in    = req_chan.clear_id;
               rd_in     = '0;
               wr_in     = '0;
               nfire_in  = '0;
               new_id_in = '0;
               status_in = STATUS_OK;
               if (op_in inside {REQ_PERIODIC, REQ_ONESHOT}) begin
                  if (cnt_ff == CW'(NUM_TIMERS)) begin
                     status_in = STATUS_FULL;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_CREATE;
                  end
               end else if (cnt_ff == '0) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_CREATE: begin
            mem_we          = 1'b1;
            mem_wa          = cnt_ff[IW-1:0];
            mem_wd.id       = next_id_ff;
            mem_wd.interval = iv_ff;
            mem_wd.deadline = add_sat;
            mem_wd.periodic = (op_ff == REQ_PERIODIC);
            new_id_in       = next_id_ff;
            next_id_in      = (next_id_ff == 16'hFFFF || next_id_ff == 16'd0) ?
                              16'd1 : next_id_ff + 16'd1;
            cnt_in          = cnt_ff + CW'(1);
            state_in        = S_DONE;
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (op_ff == REQ_CLEAR) begin
               keep = (rdata_ff.id != cid_ff);
            end else if (due) begin
               push.valid = 1'b1;
               push.id    = rdata_ff.id;
               nfire_in   = nfire_ff + FILL_W'(1);
               if (rdata_ff.periodic) begin
                  mem_wd.deadline = add_sat;
               end else begin
                  keep = 1'b0;
               end
            end
            if (keep) begin
               mem_we = 1'b1;
               wr_in  = wr_ff + CW'(1);
            end
            if (CW'(rd_ff) + CW'(1) == cnt_ff) begin
               cnt_in   = wr_in;
               state_in = S_DONE;
            end else begin
               rd_in    = rd_ff + IW'(1);
               state_in = S_READ;
            end
         end
         S_DONE: begin
            done.valid  = 1'b1;
            done.new_id = new_id_ff;
            done.status = status_ff;
            done.count  = 5'(cnt_ff);
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_wa] <= mem_wd;
      end
      rdata_ff <= slot_mem[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cnt_ff     <= '0;
         next_id_ff <= 16'd1;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         next_id_ff <= next_id_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      now_ff    <= now_in;
      iv_ff     <= iv_in;
      cid_ff    <= cid_in;
      rd_ff     <= rd_in;
      wr_ff     <= wr_in;
      nfire_ff  <= nfire_in;
      new_id_ff <= new_id_in;
      status_ff <= status_in;
   end

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(NUM_TIMERS))
      else $error("entry count beyond table depth");
   a_push_in_eval: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> (state_ff == S_EVAL) && (op_ff == REQ_TICK))
      else $error("fire word outside tick scan");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done.valid |=> (state_ff == S_IDLE))
      else $error("sequencer did not return to idle");
   a_next_id_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CREATE) |=> (next_id_ff != 16'd0))
      else $error("zero id allocated");
`endif

endmodule
`default_nettype wire

[design/tst_emit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tst_emit
// Fire id buffer and response output register. Collects fire ids during a
// scan, then streams one response word per fire (or a single word) with the
// final table count.
// ----------------------------------------------------------------------------
module tst_emit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  tst_pkg::tst_push_type  push,
   input  tst_pkg::tst_done_type  done,
   output logic                   emit_free,
   tst_rsp_if.source              rsp_chan
);
   import tst_pkg::*;

   logic [15:0]       buf_ff [MAX_RESULTS];
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [BUF_W-1:0]  rd_ff, rd_in;
   logic              pend_ff, pend_in;
   tst_done_type      sum_ff;
   logic              out_vld_ff, out_vld_in;
   logic              fired_ff;
   logic [15:0]       fired_id_ff;
   logic [15:0]       new_id_ff;
   logic              status_ff;
   logic [4:0]        count_ff;
   logic              last_ff;
   logic              load;
   logic              is_last;

   assign emit_free = !pend_ff;
   assign load      = pend_ff && (!out_vld_ff || rsp_chan.ready);
   assign is_last   = (fill_ff == '0) || (FILL_W'(rd_ff) + FILL_W'(1) == fill_ff);

   always_comb begin
      fill_in    = fill_ff;
      rd_in      = rd_ff;
      pend_in    = pend_ff;
      out_vld_in = out_vld_ff;
      if (rsp_chan.ready) begin
         out_vld_in = 1'b0;
      end
      if (push.valid) begin
         fill_in = fill_ff + FILL_W'(1);
      end
      if (done.valid) begin
         pend_in = 1'b1;
      end
      if (load) begin
         out_vld_in = 1'b1;
         if (is_last) begin
            pend_in = 1'b0;
            rd_in   = '0;
            fill_in = '0;
         end else begin
            rd_in = rd_ff + BUF_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         rd_ff      <= '0;
         pend_ff    <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         fill_ff    <= fill_in;
         rd_ff      <= rd_in;
         pend_ff    <= pend_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         buf_ff[fill_ff[BUF_W-1:0]] <= push.id;
      end
      if (done.valid) begin
         sum_ff <= done;
      end
      if (load) begin
         fired_ff    <= (fill_ff != '0);
         fired_id_ff <= (fill_ff != '0) ? buf_ff[rd_ff] : 16'd0;
         new_id_ff   <= sum_ff.new_id;
         status_ff   <= sum_ff.status;
         count_ff    <= sum_ff.count;
         last_ff     <= is_last;
      end
   end

   assign rsp_chan.valid        = out_vld_ff;
   assign rsp_chan.fired        = fired_ff;
   assign rsp_chan.fired_id     = fired_id_ff;
   assign rsp_chan.new_id       = new_id_ff;
   assign rsp_chan.status       = status_ff;
   assign rsp_chan.active_count = count_ff;
   assign rsp_chan.last         = last_ff;

`ifndef SYNTHESIS
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> (fill_ff < FILL_W'(MAX_RESULTS)) && !pend_ff)
      else $error("fire buffer overrun");
   a_done_free: assert property (@(posedge clock) disable iff (reset)
      done.valid |-> !pend_ff)
      else $error("summary while previous request pending");
   a_load_progress: assert property (@(posedge clock) disable iff (reset)
      (pend_ff && !out_vld_ff) |=> out_vld_ff)
      else $error("pending word not loaded");
`endif

endmodule
`default_nettype wire

[design/software_timer_table_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// software_timer_table_core
// Table of up to NUM_TIMERS one-shot and periodic software timers.
// ----------------------------------------------------------------------------
// Requests are taken one at a time. A create passes through the create and
// done states to its response. A tick or clear walks the live entries in
// creation order, each with a slot memory read, then evaluate and write back
// (a tick through the shared deadline compare and saturating adder), before
// its first response word; a tick then delivers one word per fire, back to
// back while the receiver is ready. The next request is taken once the
// previous one's last word sits in the output register.
module software_timer_table_core #(
   parameter int NUM_TIMERS = tst_pkg::NUM_TIMERS_DEFAULT
) (
   input wire logic  clock,
   input wire logic  reset,
   tst_req_if.sink   req_chan,
   tst_rsp_if.source rsp_chan
);
   import tst_pkg::*;

   tst_push_type push;
   tst_done_type done;
   logic         emit_free;

   tst_scan #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .emit_free (emit_free),
      .push      (push),
      .done      (done)
   );

   tst_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .done      (done),
      .emit_free (emit_free),
      .rsp_chan  (rsp_chan)
   );

endmodule
`default_nettype wire
